[src/dspm_pkg.sv]
// shared types and constants of the dot-star pattern matcher
`default_nettype none

package dspm_pkg;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_APPEND  = 2'd1;
    localparam logic [1:0] CMD_TEXT    = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    localparam logic [7:0] DOT_BYTE  = 8'h2E;
    localparam logic [7:0] STAR_BYTE = 8'h2A;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_APPEND,
        OP_TEXT,
        OP_RESTART
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] symbol;
    } t_ctrl;

    // what one cell hands to the next one
    typedef struct packed {
        logic head;
        logic step;
        logic skip_near;
        logic skip_far;
        logic used_old;
        logic star_old;
        logic used_new;
        logic hit;
    } t_link;

endpackage

`default_nettype wire

[src/dspm_if.sv]
// handshake channels of the dot-star pattern matcher
`default_nettype none

interface dspm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] symbol;

    modport source (output valid, output command, output symbol, input ready);
    modport sink   (input valid, input command, input symbol, output ready);
endinterface

interface dspm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic overflow;

    modport source (output valid, output matched, output overflow, input ready);
    modport sink   (input valid, input matched, input overflow, output ready);
endinterface

`default_nettype wire

[src/dspm_cell.sv]
// one pattern position: stored byte, star flag, fill flag and active bit
`default_nettype none

module dspm_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dspm_pkg::t_ctrl i_ctrl,
    input  dspm_pkg::t_link i_link,
    input  logic            i_next_used,
    output dspm_pkg::t_link o_link
);

    logic [7:0] r_byte;
    logic       r_used;
    logic       r_star;
    logic       r_act;

    logic [7:0] n_byte;
    logic       n_used;
    logic       n_star;
    logic       n_act;

    logic sym_hit;
    logic is_text;
    logic stay;
    logic step_out;
    logic wr;
    logic set_star;

    always_comb begin
        sym_hit  = r_used && (r_byte == i_ctrl.symbol || r_byte == dspm_pkg::DOT_BYTE);
        is_text  = (i_ctrl.op == dspm_pkg::OP_TEXT);
        stay     = is_text && r_act && sym_hit && r_star;
        step_out = is_text && r_act && sym_hit && !r_star;
        // first free cell takes the appended byte
        wr       = (i_ctrl.op == dspm_pkg::OP_APPEND) && i_link.used_old && !r_used;
        // last element gets starred unless it or its predecessor is already starred
        set_star = (i_ctrl.op == dspm_pkg::OP_APPEND) && r_used && !i_next_used
                   && (i_ctrl.symbol == dspm_pkg::STAR_BYTE)
                   && !i_link.star_old && !r_star;

        n_byte = r_byte;
        n_used = r_used;
        n_star = r_star;
        case (i_ctrl.op)
            dspm_pkg::OP_CLEAR: begin
                n_used = 1'b0;
                n_star = 1'b0;
            end
            dspm_pkg::OP_APPEND: begin
                if (wr) begin
                    n_used = 1'b1;
                    n_star = 1'b0;
                    n_byte = i_ctrl.symbol;
                end
                if (set_star) begin
                    n_star = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // skip_far carries the closure from two cells back
        if (i_ctrl.op == dspm_pkg::OP_NONE) begin
            n_act = r_act;
        end else begin
            n_act = i_link.step || stay || i_link.skip_far;
        end

        o_link.head      = 1'b0;
        o_link.step      = step_out;
        o_link.skip_near = n_act && n_star;
        o_link.skip_far  = i_link.skip_near;
        o_link.used_old  = r_used;
        o_link.star_old  = r_star;
        o_link.used_new  = n_used;
        // active bit at the end of the pattern
        o_link.hit       = i_link.hit || (n_act && !n_used && i_link.used_new);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_star <= 1'b0;
            r_act  <= i_link.head;
        end else begin
            r_used <= n_used;
            r_star <= n_star;
            r_act  <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

`default_nettype wire

[src/dot_star_pattern_matcher_core.sv]
// top level of the dot-star pattern matcher
`default_nettype none

// Whole-string matcher for patterns of literal bytes, '.' and 'x*'. Commands load
// the pattern one byte at a time (clear, append) and stream text bytes (text,
// restart); every accepted word yields one result word telling whether the text
// since the last restart, clear or append matches the whole pattern, plus a
// sticky overflow flag for pattern bytes dropped beyond MAX_PATTERN. One word is
// taken per clock while the output register is free or being read: the row of
// MAX_PATTERN position cells computes its next active bits combinationally, with
// the star closure and the end-of-pattern test rippling through the cells, so
// the cell count sets the critical path. The result lands in the output register
// the cycle after acceptance; the input is ready while it is empty or being read.
module dot_star_pattern_matcher_core #(
    parameter int MAX_PATTERN = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dspm_in_if.sink       i_req,
    dspm_out_if.source    o_rsp
);

    dspm_pkg::t_link links [MAX_PATTERN+1];
    dspm_pkg::t_ctrl ctrl;

    logic r_act_end;
    logic n_act_end;
    logic r_overflow_seen;
    logic n_overflow_seen;
    logic r_out_valid;
    logic r_matched;
    logic r_overflow;
    logic accept;
    logic full;
    logic restarting;
    logic matched_n;

    assign i_req.ready    = !r_out_valid || o_rsp.ready;
    assign accept         = i_req.valid && i_req.ready;
    assign full           = links[MAX_PATTERN].used_old;
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.matched  = r_matched;
    assign o_rsp.overflow = r_overflow;

    always_comb begin
        ctrl.symbol     = i_req.symbol;
        ctrl.op         = dspm_pkg::OP_NONE;
        n_overflow_seen = r_overflow_seen;
        if (accept) begin
            case (i_req.command)
                dspm_pkg::CMD_CLEAR: begin
                    ctrl.op         = dspm_pkg::OP_CLEAR;
                    n_overflow_seen = 1'b0;
                end
                dspm_pkg::CMD_APPEND: begin
                    if (full) begin
                        n_overflow_seen = 1'b1;
                    end else begin
                        ctrl.op = dspm_pkg::OP_APPEND;
                    end
                end
                dspm_pkg::CMD_TEXT:    ctrl.op = dspm_pkg::OP_TEXT;
                dspm_pkg::CMD_RESTART: ctrl.op = dspm_pkg::OP_RESTART;
                default:               ctrl.op = dspm_pkg::OP_NONE;
            endcase
        end
        restarting = (ctrl.op == dspm_pkg::OP_CLEAR) || (ctrl.op == dspm_pkg::OP_APPEND)
                     || (ctrl.op == dspm_pkg::OP_RESTART);
    end

    // head of the row: position zero is reactivated on a restart, clear or append
    assign links[0] = '{head: 1'b1, step: restarting, skip_near: 1'b0, skip_far: 1'b0,
                        used_old: 1'b1, star_old: 1'b0, used_new: 1'b1, hit: 1'b0};

    always_comb begin
        // position past the last cell
        if (ctrl.op == dspm_pkg::OP_NONE) begin
            n_act_end = r_act_end;
        end else begin
            n_act_end = links[MAX_PATTERN].step || links[MAX_PATTERN].skip_far;
        end
        matched_n = links[MAX_PATTERN].hit || (n_act_end && links[MAX_PATTERN].used_new);
    end

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        logic next_used;
        if (g + 1 < MAX_PATTERN) begin : g_mid
            assign next_used = links[g+2].used_old;
        end else begin : g_last
            assign next_used = 1'b0;
        end

        dspm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_link      (links[g]),
            .i_next_used (next_used),
            .o_link      (links[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_end       <= 1'b0;
            r_overflow_seen <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_act_end       <= n_act_end;
            r_overflow_seen <= n_overflow_seen;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_matched  <= matched_n;
            r_overflow <= n_overflow_seen;
        end
    end

endmodule

`default_nettype wire
